>>> rtl/core/lsud_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsud_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DUMP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Per-cell control: load takes the pushed value, shift takes the neighbor's value.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/lsud_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface lsud_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          opcode;
    logic signed [lsud_pkg::DATA_W-1:0]  value;
    logic signed [lsud_pkg::DATA_W-1:0]  new_value;

    modport source (output valid, output opcode, output value, output new_value, input ready);
    modport sink   (input valid, input opcode, input value, input new_value, output ready);
endinterface

interface lsud_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [lsud_pkg::DATA_W-1:0]  data;
    logic                                last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/stack_with_update_and_dump_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Push and pop: the answer goes straight into the response register; a new request each
// cycle while the response side does not stall. Update and dump of a non-empty stack
// rotate the cells DEPTH times, one step each time the response side can take a result;
// no request is taken meanwhile. Dump answers one entry per live step, bottom first;
// update answers at the end. An empty stack answers update and dump at once, like pop.
// Reset (rst_n low, async) clears the entry count and the handshake state only;
// the stored entries stay undefined and there is no clearing pass.

module stack_with_update_and_dump_top #(
    parameter int DEPTH = lsud_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    lsud_req_if.sink          req,
    lsud_rsp_if.source        rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = lsud_pkg::DATA_W;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              step_reg, step_next;
    logic                       found_reg, found_next;
    lsud_pkg::op_t              op_reg;
    logic signed [DW-1:0]       val_reg;
    logic signed [DW-1:0]       nval_reg;

    logic                       out_valid_reg, out_valid_next;
    lsud_pkg::status_t          out_status_reg, out_status_next;
    logic signed [DW-1:0]       out_data_reg, out_data_next;
    logic                       out_last_reg, out_last_next;

    logic signed [DW-1:0]       cell_q   [DEPTH];
    logic signed [DW-1:0]       pop_sel  [DEPTH];
    lsud_pkg::cell_ctrl_t       cell_ctrl [DEPTH];
    logic signed [DW-1:0]       wrap_data;
    logic signed [DW-1:0]       pop_data;

    lsud_pkg::op_t              req_op;
    logic                       out_free;
    logic                       in_fire;
    logic                       full;
    logic                       empty;
    logic                       scan_adv;
    logic                       live;
    logic                       match;
    logic                       scan_end;
    logic                       push_ok;

    // ------------------------------------------------------------------
    // Handshake and status decode
    // ------------------------------------------------------------------
    assign req_op   = lsud_pkg::op_t'(req.opcode);
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = req.valid && req.ready;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign push_ok  = in_fire && (req_op == lsud_pkg::OP_PUSH) && !full;

    // A scan step advances only when the response register can take a result.
    assign scan_adv = (state_reg == S_SCAN) && out_free;
    // Cell 0 holds entries[step] during the scan; steps at or past count are stale.
    assign live     = (step_reg < count_reg);
    assign match    = (op_reg == lsud_pkg::OP_UPDATE) && live && !found_reg
                      && (cell_q[0] == val_reg);
    assign scan_end = (step_reg == CW'(DEPTH - 1));
    // The entry leaving cell 0 wraps to the far end; replace it on the first match.
    assign wrap_data = match ? nval_reg : cell_q[0];

    // ------------------------------------------------------------------
    // Cell chain: cell i holds entries[i]; a rotate moves every cell one
    // place toward cell 0, and DEPTH rotates restore the original order.
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [DW-1:0] shift_src;

            if (gi == DEPTH - 1)
            begin : g_wrap
                assign shift_src = wrap_data;
            end
            else
            begin : g_link
                assign shift_src = cell_q[gi + 1];
            end

            // Load on a push into this slot, shift on every scan step.
            assign cell_ctrl[gi] = {push_ok && (count_reg == CW'(gi)), scan_adv};
            // Top-of-stack select for pop: the cell just below count.
            assign pop_sel[gi] = (count_reg == CW'(gi + 1)) ? cell_q[gi] : '0;

            lsud_cell #(
                .WIDTH (DW)
            ) u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl[gi]),
                .load_data (req.value),
                .shift_in  (shift_src),
                .q         (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        pop_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            pop_data = pop_data | pop_sel[i];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and response register
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        if (in_fire)
        begin
            // Default single response for this request; arms below refine it.
            out_valid_next  = 1'b1;
            out_status_next = lsud_pkg::ST_OK;
            out_data_next   = '0;
            out_last_next   = 1'b1;
            unique case (req_op) inside
                lsud_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        out_status_next = lsud_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                lsud_pkg::OP_POP:
                begin
                    if (empty)
                    begin
                        out_status_next = lsud_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next    = count_reg - CW'(1);
                        out_data_next = pop_data;
                    end
                end
                lsud_pkg::OP_UPDATE, lsud_pkg::OP_DUMP:
                begin
                    if (empty)
                    begin
                        out_status_next = lsud_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // Hold the response slot empty and start the rotation.
                        out_valid_next = 1'b0;
                        state_next     = S_SCAN;
                        step_next      = '0;
                        found_next     = 1'b0;
                    end
                end
                default:
                begin
                    out_valid_next = 1'b0;
                end
            endcase
        end

        if (scan_adv)
        begin
            step_next = step_reg + CW'(1);
            if (match)
            begin
                found_next = 1'b1;
            end
            if ((op_reg == lsud_pkg::OP_DUMP) && live)
            begin
                out_valid_next  = 1'b1;
                out_status_next = lsud_pkg::ST_OK;
                out_data_next   = cell_q[0];
                out_last_next   = ((step_reg + CW'(1)) == count_reg);
            end
            if (scan_end)
            begin
                state_next = S_IDLE;
                if (op_reg == lsud_pkg::OP_UPDATE)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = (found_reg || match) ? lsud_pkg::ST_OK
                                                           : lsud_pkg::ST_NOTFOUND;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture the request and drive the response fields.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= req_op;
            val_reg  <= req.value;
            nval_reg <= req.new_value;
        end
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.last   = out_last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !req.ready)
        else $error("request accepted during a scan");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not grow the stack");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_adv && scan_end && (op_reg == lsud_pkg::OP_UPDATE))
        |=> (state_reg == S_IDLE) && rsp.valid)
        else $error("scan end did not return to idle with a response");

    a_scan_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> $stable(count_reg))
        else $error("entry count changed during a scan");
`endif

endmodule

`default_nettype wire

>>> rtl/core/lsud_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lsud_cell #(
    parameter int WIDTH = lsud_pkg::DATA_W
) (
    input  logic                    clk,
    input  lsud_pkg::cell_ctrl_t    ctrl,
    input  logic signed [WIDTH-1:0] load_data,
    input  logic signed [WIDTH-1:0] shift_in,
    output logic signed [WIDTH-1:0] q
);

    logic signed [WIDTH-1:0] entry_reg;
    logic signed [WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = load_data;
        end
        else if (ctrl.shift)
        begin
            entry_next = shift_in;
        end
    end

    // Contents stay undefined until written.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

`default_nettype wire
